// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the frame reassembler.
// Depends on nothing; included by bare name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is held off while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Clocked assertion that is also checked while reset is asserted.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== sv/l2fr_pkg.sv =====
// Shared types, codes and helpers for the L2CAP frame reassembler.
// Depends on nothing; used by every module of the block.
package l2fr_pkg;

    // Default frame buffer size in bytes.
    localparam int BUF_BYTES_DEF = 512;

    // Width of the unwrapped length plus header sum (16-bit length + 4).
    localparam int TOT_W = 17;

    // L2CAP basic header size.
    localparam logic [7:0] HDR_BYTES = 8'd4;

    // Link-layer id codes.
    localparam logic [1:0] LLID_CONT  = 2'd1;
    localparam logic [1:0] LLID_START = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_STORED   = 2'd0;
    localparam logic [1:0] ST_IGNORED  = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;
    localparam logic [1:0] ST_OVERSIZE = 2'd3;

    // Fixed channel identifiers.
    localparam logic [15:0] CID_SIGNALING = 16'h0005;
    localparam logic [15:0] CID_ATT       = 16'h0004;
    localparam logic [15:0] CID_SMP       = 16'h0006;

    // Channel class codes.
    localparam logic [1:0] CLS_SIGNALING = 2'd0;
    localparam logic [1:0] CLS_ATT       = 2'd1;
    localparam logic [1:0] CLS_SMP       = 2'd2;
    localparam logic [1:0] CLS_OTHER     = 2'd3;

    // One input item.
    typedef struct packed {
        logic [1:0] llid;
        logic [7:0] frag_len;
        logic [7:0] byte_index;
        logic [7:0] data_byte;
    } item_t;

    // Map a channel identifier to its class.
    function automatic logic [1:0] class_of(input logic [15:0] cid);
        logic [1:0] cls;
        if (cid == CID_SIGNALING) begin
            cls = CLS_SIGNALING;
        end else if (cid == CID_ATT) begin
            cls = CLS_ATT;
        end else if (cid == CID_SMP) begin
            cls = CLS_SMP;
        end else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

endpackage

// ===== sv/l2fr_in_reg.sv =====
// Input register stage of the frame reassembler.
// Depends on l2fr_pkg for the item type.
module l2fr_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  l2fr_pkg::item_t s_item,
    input  logic            take,
    output logic            item_valid,
    output l2fr_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    l2fr_pkg::item_t item_reg;

    // The stage can load when empty or when its item moves on this cycle.
    assign s_ready = !valid_reg || take;

    always_comb begin
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    // Valid flag is control state and is reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, loaded on every accepted item.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== sv/l2fr_core.sv =====
// Reassembly state, per-item decision logic and result register.
// Depends on l2fr_pkg for codes, the item type and the class lookup.
module l2fr_core #(
    parameter int BUF_BYTES = l2fr_pkg::BUF_BYTES_DEF,
    parameter int ADDR_W    = $clog2(BUF_BYTES),
    parameter int CNT_W     = $clog2(BUF_BYTES + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  l2fr_pkg::item_t   item,
    output logic              take,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic              m_store_enable,
    output logic [ADDR_W-1:0] m_store_addr,
    output logic [7:0]        m_store_byte,
    output logic              m_frame_done,
    output logic [CNT_W-1:0]  m_frame_total,
    output logic [15:0]       m_channel_id,
    output logic [1:0]        m_channel_class
);

    localparam logic [l2fr_pkg::TOT_W-1:0] BUF_LIM = l2fr_pkg::TOT_W'(BUF_BYTES);
    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO = CNT_W'(2);
    localparam logic [CNT_W-1:0] THREE = CNT_W'(3);

    // Reassembly state.
    logic             open_reg,     open_next;
    logic [CNT_W-1:0] expected_reg, expected_next;
    logic [CNT_W-1:0] stored_reg,   stored_next;
    logic [7:0]       len_low_reg,  len_low_next;
    logic [15:0]      channel_reg,  channel_next;

    // Result register.
    logic              valid_reg, valid_next;
    logic [1:0]        status_reg, status_next;
    logic              en_reg, en_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [7:0]        byte_reg, byte_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [15:0]       cid_reg, cid_next;
    logic [1:0]        cls_reg, cls_next;

    // Decode helpers.
    logic                         is_start;
    logic                         is_cont;
    logic                         short_start;
    logic                         in_range;
    logic                         do_append;
    logic [l2fr_pkg::TOT_W-1:0]   len_total;
    logic                         oversize;
    logic [CNT_W-1:0]             exp_eff;
    logic [CNT_W-1:0]             count_inc;

    // An item moves on when the result register is free or being drained.
    assign take = item_valid && (!valid_reg || m_ready);

    assign is_start    = (item.llid == l2fr_pkg::LLID_START);
    assign is_cont     = (item.llid == l2fr_pkg::LLID_CONT);
    assign short_start = is_start && (item.frag_len < l2fr_pkg::HDR_BYTES);
    assign in_range    = (item.byte_index < item.frag_len);
    assign do_append   = open_reg && in_range &&
                         (is_cont || (is_start && !short_start && item.byte_index != 8'd0));

    // Header length plus header size, kept wide so that it never wraps.
    assign len_total = l2fr_pkg::TOT_W'(len_low_reg) +
                       l2fr_pkg::TOT_W'({item.data_byte, 8'd0}) +
                       l2fr_pkg::TOT_W'(l2fr_pkg::HDR_BYTES);
    assign oversize  = (stored_reg == ONE) && (len_total > BUF_LIM);
    assign exp_eff   = (stored_reg == ONE) ? len_total[CNT_W-1:0] : expected_reg;
    assign count_inc = stored_reg + ONE;

    // Next state and result for the item in the input register.
    always_comb begin
        open_next     = open_reg;
        expected_next = expected_reg;
        stored_next   = stored_reg;
        len_low_next  = len_low_reg;
        channel_next  = channel_reg;

        status_next = l2fr_pkg::ST_IGNORED;
        en_next     = 1'b0;
        addr_next   = '0;
        byte_next   = 8'd0;
        done_next   = 1'b0;
        total_next  = '0;
        cid_next    = 16'd0;
        cls_next    = 2'd0;

        if (short_start) begin
            // A start fragment too short for a header closes any frame.
            open_next   = 1'b0;
            status_next = l2fr_pkg::ST_SHORT;
        end else if (is_start && item.byte_index == 8'd0) begin
            // First byte of a start fragment long enough for a header opens a fresh frame.
            open_next     = 1'b1;
            expected_next = '0;
            stored_next   = ONE;
            len_low_next  = item.data_byte;
            channel_next  = 16'd0;
            status_next   = l2fr_pkg::ST_STORED;
            en_next       = 1'b1;
            byte_next     = item.data_byte;
        end else if (do_append) begin
            if (oversize) begin
                open_next   = 1'b0;
                status_next = l2fr_pkg::ST_OVERSIZE;
            end else begin
                if (stored_reg == ONE) begin
                    expected_next = len_total[CNT_W-1:0];
                end else if (stored_reg == TWO) begin
                    channel_next = {channel_reg[15:8], item.data_byte};
                end else if (stored_reg == THREE) begin
                    channel_next = {item.data_byte, channel_reg[7:0]};
                end
                status_next = l2fr_pkg::ST_STORED;
                en_next     = 1'b1;
                addr_next   = stored_reg[ADDR_W-1:0];
                byte_next   = item.data_byte;
                stored_next = count_inc;
                // The frame is complete once the stored count meets its total.
                if (count_inc >= TWO && count_inc >= exp_eff) begin
                    open_next  = 1'b0;
                    done_next  = 1'b1;
                    total_next = exp_eff;
                    cid_next   = channel_next;
                    cls_next   = l2fr_pkg::class_of(channel_next);
                end
            end
        end
    end

    always_comb begin
        if (take) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            open_reg     <= 1'b0;
            expected_reg <= '0;
            stored_reg   <= '0;
            len_low_reg  <= 8'd0;
            channel_reg  <= 16'd0;
        end else begin
            valid_reg <= valid_next;
            if (take) begin
                open_reg     <= open_next;
                expected_reg <= expected_next;
                stored_reg   <= stored_next;
                len_low_reg  <= len_low_next;
                channel_reg  <= channel_next;
            end
        end
    end

    // Result payload, loaded with each item that moves on.
    always_ff @(posedge aclk) begin
        if (take) begin
            status_reg <= status_next;
            en_reg     <= en_next;
            addr_reg   <= addr_next;
            byte_reg   <= byte_next;
            done_reg   <= done_next;
            total_reg  <= total_next;
            cid_reg    <= cid_next;
            cls_reg    <= cls_next;
        end
    end

    assign m_valid         = valid_reg;
    assign m_status        = status_reg;
    assign m_store_enable  = en_reg;
    assign m_store_addr    = addr_reg;
    assign m_store_byte    = byte_reg;
    assign m_frame_done    = done_reg;
    assign m_frame_total   = total_reg;
    assign m_channel_id    = cid_reg;
    assign m_channel_class = cls_reg;

endmodule

// ===== sv/l2cap_frame_reassembler.sv =====
// L2CAP frame reassembler top level: input register followed by the core.
// An accepted item is registered in the input register and then in the
// result register once that register is free or being drained.
// Throughput: one item per cycle, set by the single-pass core between
// the input register and the result register; stalls only on m_ready.
// Reset: synchronous, active low; clears handshake flags and frame state.
module l2cap_frame_reassembler #(
    parameter int BUF_BYTES = l2fr_pkg::BUF_BYTES_DEF,
    parameter int ADDR_W    = $clog2(BUF_BYTES),
    parameter int CNT_W     = $clog2(BUF_BYTES + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_llid,
    input  logic [7:0]        s_frag_len,
    input  logic [7:0]        s_byte_index,
    input  logic [7:0]        s_data_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic              m_store_enable,
    output logic [ADDR_W-1:0] m_store_addr,
    output logic [7:0]        m_store_byte,
    output logic              m_frame_done,
    output logic [CNT_W-1:0]  m_frame_total,
    output logic [15:0]       m_channel_id,
    output logic [1:0]        m_channel_class
);

    l2fr_pkg::item_t s_item;
    l2fr_pkg::item_t item;
    logic            item_valid;
    logic            take;

    // Gather the input ports into one item.
    assign s_item = '{llid:       s_llid,
                      frag_len:   s_frag_len,
                      byte_index: s_byte_index,
                      data_byte:  s_data_byte};

    l2fr_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    l2fr_core #(
        .BUF_BYTES (BUF_BYTES),
        .ADDR_W    (ADDR_W),
        .CNT_W     (CNT_W)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_valid      (item_valid),
        .item            (item),
        .take            (take),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_store_enable  (m_store_enable),
        .m_store_addr    (m_store_addr),
        .m_store_byte    (m_store_byte),
        .m_frame_done    (m_frame_done),
        .m_frame_total   (m_frame_total),
        .m_channel_id    (m_channel_id),
        .m_channel_class (m_channel_class)
    );

endmodule

// ===== sv/l2fr_checker.sv =====
// Port-level checker for the frame reassembler and its bind statement.
// Depends on l2fr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module l2fr_checker #(
    parameter int BUF_BYTES = l2fr_pkg::BUF_BYTES_DEF,
    parameter int ADDR_W    = $clog2(BUF_BYTES),
    parameter int CNT_W     = $clog2(BUF_BYTES + 1)
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [1:0]        m_status,
    input logic              m_store_enable,
    input logic [ADDR_W-1:0] m_store_addr,
    input logic              m_frame_done,
    input logic [CNT_W-1:0]  m_frame_total,
    input logic [1:0]        m_channel_class
);

    // A stalled result item holds its status and done flag.
    `ASSERT_CLK(a_hold, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_frame_done))

    // A store is issued exactly for items reported as stored.
    `ASSERT_CLK(a_store_status, aclk, aresetn,
        m_valid |-> (m_store_enable == (m_status == l2fr_pkg::ST_STORED)))

    // A completed frame ends on a stored byte whose address is its last one.
    `ASSERT_CLK(a_done_addr, aclk, aresetn,
        m_valid && m_frame_done |-> m_store_enable &&
        (CNT_W'(m_store_addr) + CNT_W'(1) == m_frame_total))

    // A completed frame holds at least its header and fits the buffer.
    `ASSERT_CLK(a_done_total, aclk, aresetn,
        m_valid && m_frame_done |-> m_frame_total >= CNT_W'(l2fr_pkg::HDR_BYTES) &&
        m_frame_total <= CNT_W'(BUF_BYTES))

    // Without a completed frame the class field stays at zero.
    `ASSERT_CLK(a_class_idle, aclk, aresetn,
        m_valid && !m_frame_done |-> m_channel_class == l2fr_pkg::CLS_SIGNALING)

endmodule

bind l2cap_frame_reassembler l2fr_checker #(
    .BUF_BYTES (BUF_BYTES),
    .ADDR_W    (ADDR_W),
    .CNT_W     (CNT_W)
) u_l2fr_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_store_enable  (m_store_enable),
    .m_store_addr    (m_store_addr),
    .m_frame_done    (m_frame_done),
    .m_frame_total   (m_frame_total),
    .m_channel_class (m_channel_class)
);
